@@ rtl/linked_block_allocator_core_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro expects aclk and aresetn in scope; no other dependencies.
`ifndef LINKED_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define LINKED_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lba_pkg.sv @@
// Shared types and codes for the linked block allocator.
// No dependencies; used by the front, back and top-level modules.
`timescale 1ns / 1ps

package lba_pkg;

    localparam int FID_W  = 8;
    localparam int BIDX_W = 6;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FREE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_LIST  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_LIST,
        CMD_BAD_RANGE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [FID_W-1:0]  file_id;
        logic [BIDX_W-1:0] range_start;
        logic [BIDX_W-1:0] range_end;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT,
        ST_FOLLOW,
        ST_REPLY
    } eng_state_t;

endpackage

@@ rtl/linked_block_allocator_core.sv @@
// Linked block allocator: one item at a time through a two-entry command queue.
// Allocate visits each block of the range once in ALLOC, then replies; a bad range goes straight to REPLY.
// List scans each free or pointed-to block once, checks the owner of each candidate head, then
// emits the chain through EMIT and FOLLOW; the queue takes items while the single engine works.
// Reset is synchronous, active low, and frees every block at once; no clearing pass.
`timescale 1ns / 1ps

module linked_block_allocator_core #(
    parameter int BLOCKS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // file_id[7:0], range_start[13:8], range_end[19:14]
    input  logic [0:0]  s_axis_tuser,  // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // status[1:0], block_index[7:2]
    output logic        m_axis_tlast
);
    import lba_pkg::*;

    cmd_t              cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    logic [STAT_W-1:0] status;
    logic [BIDX_W-1:0] block_index;

    lba_front #(.BLOCKS(BLOCKS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .s_opcode      (s_axis_tuser[0]),
        .s_file_id     (s_axis_tdata[7:0]),
        .s_range_start (s_axis_tdata[13:8]),
        .s_range_end   (s_axis_tdata[19:14]),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd)
    );

    lba_back #(.BLOCKS(BLOCKS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_status      (status),
        .m_block_index (block_index),
        .m_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {block_index, status};

endmodule

@@ rtl/lba_front.sv @@
// Front end: accepts input items, classifies them and queues commands.
// Depends on lba_pkg for the command struct and opcode codes.
`timescale 1ns / 1ps

module lba_front #(
    parameter int BLOCKS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [lba_pkg::FID_W-1:0]  s_file_id,
    input  logic [lba_pkg::BIDX_W-1:0] s_range_start,
    input  logic [lba_pkg::BIDX_W-1:0] s_range_end,
    output logic                       cmd_valid,
    input  logic                       cmd_pop,
    output lba_pkg::cmd_t              cmd
);
    import lba_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    cmd_t        in_cmd;
    logic        push;

    // Range end is checked against the store size, start against end.
    always_comb begin
        in_cmd.file_id     = s_file_id;
        in_cmd.range_start = s_range_start;
        in_cmd.range_end   = s_range_end;
        if (s_opcode == OP_LIST) begin
            in_cmd.kind = CMD_LIST;
        end else if (({1'b0, s_range_end} >= (BIDX_W + 1)'(BLOCKS))
                     || (s_range_start > s_range_end)) begin
            in_cmd.kind = CMD_BAD_RANGE;
        end else begin
            in_cmd.kind = CMD_ALLOC;
        end
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/lba_back.sv @@
// Back end: the block store and the engine that allocates and lists chains.
// Depends on lba_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "linked_block_allocator_core_macros.svh"

module lba_back #(
    parameter int BLOCKS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    output logic                       cmd_pop,
    input  lba_pkg::cmd_t              cmd,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lba_pkg::STAT_W-1:0] m_status,
    output logic [lba_pkg::BIDX_W-1:0] m_block_index,
    output logic                       m_last
);
    import lba_pkg::*;

    localparam int IDX_W = $clog2(BLOCKS);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(BLOCKS - 1);

    eng_state_t state_reg, state_next;

    // Per-block flags live in flip-flops so reset clears them at once.
    logic [BLOCKS-1:0] used_reg;
    logic [BLOCKS-1:0] pointed_reg;
    logic [BLOCKS-1:0] linked_reg;

    logic [FID_W-1:0] owner_mem [BLOCKS];
    logic [IDX_W-1:0] link_mem  [BLOCKS];
    logic [FID_W-1:0] owner_rd_reg;
    logic [IDX_W-1:0] link_rd_reg;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  hi_reg;
    logic [FID_W-1:0]  fid_reg;
    logic [IDX_W-1:0]  prev_reg;
    logic              have_prev_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [STAT_W-1:0] reply_status_reg;
    logic [IDX_W-1:0]  reply_blk_reg;

    logic              out_vld_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [BIDX_W-1:0] out_blk_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              res_push;
    logic [STAT_W-1:0] res_status;
    logic [IDX_W-1:0]  res_block;
    logic              res_last;
    logic              claim;
    logic              cand;
    logic              owner_hit;

    assign out_free  = !out_vld_reg || m_ready;
    assign cand      = used_reg[idx_reg] && !pointed_reg[idx_reg];
    assign owner_hit = (owner_rd_reg == fid_reg);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        CMD_ALLOC:     state_next = ST_ALLOC;
                        CMD_LIST:      state_next = ST_SCAN;
                        CMD_BAD_RANGE: state_next = ST_REPLY;
                        default:       state_next = ST_REPLY;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (idx_reg == hi_reg) state_next = ST_REPLY;
            end
            ST_SCAN: begin
                if (cand) state_next = ST_CHECK;
                else if (idx_reg == IDX_MAX) state_next = ST_REPLY;
            end
            ST_CHECK: begin
                if (owner_hit) state_next = ST_EMIT;
                else if (idx_reg == IDX_MAX) state_next = ST_REPLY;
                else state_next = ST_SCAN;
            end
            ST_EMIT: begin
                if (out_free) state_next = res_last ? ST_IDLE : ST_FOLLOW;
            end
            ST_FOLLOW: state_next = ST_EMIT;
            ST_REPLY: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output and strobe logic.
    always_comb begin
        cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;
        claim      = (state_reg == ST_ALLOC) && !used_reg[idx_reg];
        res_push   = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_REPLY));
        res_status = (state_reg == ST_EMIT) ? STAT_OK : reply_status_reg;
        res_block  = (state_reg == ST_EMIT) ? cur_reg : reply_blk_reg;
        // A chain ends at a block with no link or after a full store's worth.
        res_last   = (state_reg == ST_REPLY) || !linked_reg[cur_reg] || (cnt_reg == IDX_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            pointed_reg <= '0;
            linked_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (claim) begin
                used_reg[idx_reg] <= 1'b1;
                if (have_prev_reg) begin
                    pointed_reg[idx_reg] <= 1'b1;
                    linked_reg[prev_reg] <= 1'b1;
                end
            end
            if (res_push) out_vld_reg <= 1'b1;
            else if (m_ready) out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        owner_rd_reg <= owner_mem[idx_reg];
        link_rd_reg  <= link_mem[cur_reg];
        if (claim) begin
            owner_mem[idx_reg] <= fid_reg;
            if (have_prev_reg) link_mem[prev_reg] <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            out_status_reg <= res_status;
            out_blk_reg    <= BIDX_W'(res_block);
            out_last_reg   <= res_last;
        end
        unique case (state_reg)
            ST_IDLE: begin
                fid_reg          <= cmd.file_id;
                idx_reg          <= (cmd.kind == CMD_LIST) ? '0 : IDX_W'(cmd.range_start);
                hi_reg           <= IDX_W'(cmd.range_end);
                have_prev_reg    <= 1'b0;
                reply_status_reg <= STAT_BAD_RANGE;
                reply_blk_reg    <= '0;
            end
            ST_ALLOC: begin
                if (claim) begin
                    prev_reg      <= idx_reg;
                    have_prev_reg <= 1'b1;
                    if (!have_prev_reg) first_reg <= idx_reg;
                end
                if (idx_reg == hi_reg) begin
                    reply_status_reg <= (have_prev_reg || claim) ? STAT_OK : STAT_NO_FREE;
                    reply_blk_reg    <= have_prev_reg ? first_reg : (claim ? idx_reg : '0);
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                reply_status_reg <= STAT_NOT_FOUND;
                if (!cand && idx_reg != IDX_MAX) idx_reg <= idx_reg + 1'b1;
            end
            ST_CHECK: begin
                if (owner_hit) begin
                    cur_reg <= idx_reg;
                    cnt_reg <= '0;
                end else if (idx_reg != IDX_MAX) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (res_push) cnt_reg <= cnt_reg + 1'b1;
            end
            ST_FOLLOW: cur_reg <= link_rd_reg;
            ST_REPLY: begin
            end
            default: begin
            end
        endcase
    end

    assign m_valid       = out_vld_reg;
    assign m_status      = out_status_reg;
    assign m_block_index = out_blk_reg;
    assign m_last        = out_last_reg;

    `LBA_ASSERT_NOW(a_no_overwrite, res_push, out_free, "result pushed over a waiting item")
    `LBA_ASSERT_NOW(a_pop_idle, cmd_pop, state_reg == ST_IDLE, "command taken while busy")
    `LBA_ASSERT_NOW(a_alloc_bound, state_reg == ST_ALLOC, idx_reg <= hi_reg, "allocation ran past range end")
    `LBA_ASSERT_NEXT(a_emit_follow, (state_reg == ST_EMIT) && res_push && !res_last, state_reg == ST_FOLLOW, "chain walk did not follow link")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for linked_block_allocator_core: allocation and chain listing.
// Depends on lba_pkg and the allocator RTL; a directed table runs first, then random items.
`timescale 1ns / 1ps

module tb_top;
    import lba_pkg::*;

    localparam int NBLK       = 32;
    localparam int IDLE_LIMIT = 3000;
    localparam int N_RANDOM   = 330;
    localparam int N_DIRECTED = 22;
    localparam logic [6:0] NO_LINK = 7'd127;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [BIDX_W-1:0] blk;
        logic              last;
    } chain_result_t;

    // One row of the directed table; the expected answer is used only when typed is set.
    typedef struct packed {
        logic              op;
        logic [FID_W-1:0]  fid;
        logic [BIDX_W-1:0] lo;
        logic [BIDX_W-1:0] hi;
        logic              typed;
        logic [STAT_W-1:0] st;
        logic [BIDX_W-1:0] blk;
    } directed_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // file_id[7:0], range_start[13:8], range_end[19:14]
    logic [0:0]  s_axis_tuser  = '0;  // opcode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // status[1:0], block_index[7:2]
    logic        m_axis_tlast;

    // Shadow copy of the block store.
    logic             blk_used  [NBLK];
    logic [FID_W-1:0] blk_owner [NBLK];
    logic [6:0]       blk_next  [NBLK];

    chain_result_t item_results[$];
    chain_result_t awaited_results[$];

    logic [FID_W-1:0] fid_pool [7] = '{8'd0, 8'd7, 8'd8, 8'd9, 8'd85, 8'd170, 8'd255};

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int mismatches    = 0;
    int n_alloc       = 0;
    int n_list        = 0;
    int n_checked     = 0;
    int idle_cycles   = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OP_LIST,  8'd0,   6'd0,  6'd0,  1'b1, STAT_NOT_FOUND, 6'd0},
        '{OP_ALLOC, 8'd0,   6'd0,  6'd0,  1'b1, STAT_OK,        6'd0},
        '{OP_ALLOC, 8'd255, 6'd31, 6'd31, 1'b1, STAT_OK,        6'd31},
        '{OP_ALLOC, 8'd7,   6'd5,  6'd40, 1'b1, STAT_BAD_RANGE, 6'd0},
        '{OP_ALLOC, 8'd7,   6'd10, 6'd9,  1'b1, STAT_BAD_RANGE, 6'd0},
        '{OP_ALLOC, 8'd7,   6'd63, 6'd63, 1'b1, STAT_BAD_RANGE, 6'd0},
        '{OP_ALLOC, 8'd7,   6'd1,  6'd4,  1'b1, STAT_OK,        6'd1},
        '{OP_ALLOC, 8'd7,   6'd0,  6'd1,  1'b1, STAT_NO_FREE,   6'd0},
        // Partly used range: a second chain for the same file starts at block 5.
        '{OP_ALLOC, 8'd7,   6'd3,  6'd6,  1'b1, STAT_OK,        6'd5},
        '{OP_LIST,  8'd7,   6'd0,  6'd0,  1'b0, STAT_OK,        6'd0},
        '{OP_LIST,  8'd0,   6'd63, 6'd63, 1'b0, STAT_OK,        6'd0},
        '{OP_LIST,  8'd255, 6'd42, 6'd21, 1'b0, STAT_OK,        6'd0},
        '{OP_LIST,  8'd8,   6'd0,  6'd0,  1'b1, STAT_NOT_FOUND, 6'd0},
        '{OP_ALLOC, 8'd8,   6'd8,  6'd9,  1'b1, STAT_OK,        6'd8},
        // This chain skips the blocks that file 8 now holds.
        '{OP_ALLOC, 8'd9,   6'd7,  6'd11, 1'b1, STAT_OK,        6'd7},
        '{OP_LIST,  8'd9,   6'd0,  6'd0,  1'b0, STAT_OK,        6'd0},
        '{OP_LIST,  8'd8,   6'd0,  6'd0,  1'b0, STAT_OK,        6'd0},
        '{OP_ALLOC, 8'd170, 6'd16, 6'd21, 1'b1, STAT_OK,        6'd16},
        '{OP_ALLOC, 8'd85,  6'd12, 6'd13, 1'b1, STAT_OK,        6'd12},
        '{OP_LIST,  8'd170, 6'd0,  6'd0,  1'b0, STAT_OK,        6'd0},
        '{OP_LIST,  8'd85,  6'd0,  6'd0,  1'b0, STAT_OK,        6'd0},
        '{OP_LIST,  8'd1,   6'd0,  6'd0,  1'b1, STAT_NOT_FOUND, 6'd0}
    };

    linked_block_allocator_core #(
        .BLOCKS(NBLK)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_store();
        for (int i = 0; i < NBLK; i++) begin
            blk_used[i]  = 1'b0;
            blk_owner[i] = '0;
            blk_next[i]  = NO_LINK;
        end
    endfunction

    function automatic logic is_link_target(int b);
        for (int j = 0; j < NBLK; j++)
            if (blk_next[j] == 7'(b))
                return 1'b1;
        return 1'b0;
    endfunction

    // Updates the shadow store for one item and fills item_results with its answers.
    function automatic void forecast_item(logic op, logic [FID_W-1:0] fid,
                                          logic [BIDX_W-1:0] lo, logic [BIDX_W-1:0] hi);
        int prev;
        int first;
        int cur;
        int n;
        chain_result_t r;
        item_results.delete();
        prev  = -1;
        first = 0;
        cur   = -1;
        n     = 0;
        if (op == OP_ALLOC) begin
            if (int'(hi) >= NBLK || lo > hi) begin
                item_results.push_back('{STAT_BAD_RANGE, 6'd0, 1'b1});
                return;
            end
            for (int i = int'(lo); i <= int'(hi); i++) begin
                if (!blk_used[i]) begin
                    blk_used[i]  = 1'b1;
                    blk_owner[i] = fid;
                    if (prev >= 0)
                        blk_next[prev] = 7'(i);
                    else
                        first = i;
                    prev = i;
                end
            end
            if (prev < 0)
                item_results.push_back('{STAT_NO_FREE, 6'd0, 1'b1});
            else
                item_results.push_back('{STAT_OK, 6'(first), 1'b1});
            return;
        end
        for (int i = 0; i < NBLK; i++) begin
            if (blk_used[i] && blk_owner[i] == fid && !is_link_target(i)) begin
                cur = i;
                break;
            end
        end
        if (cur < 0) begin
            item_results.push_back('{STAT_NOT_FOUND, 6'd0, 1'b1});
            return;
        end
        while (cur < NBLK && n < NBLK) begin
            item_results.push_back('{STAT_OK, 6'(cur), 1'b0});
            n++;
            cur = int'(blk_next[cur]);
        end
        r = item_results[$];
        r.last = 1'b1;
        item_results[item_results.size()-1] = r;
    endfunction

    // Offers one item, waits for its acceptance, then queues what it should cause.
    task automatic send_item(logic op, logic [FID_W-1:0] fid, logic [BIDX_W-1:0] lo,
                             logic [BIDX_W-1:0] hi, logic typed, logic [STAT_W-1:0] st,
                             logic [BIDX_W-1:0] blk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, hi, lo, fid};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        forecast_item(op, fid, lo, hi);
        if (typed)
            awaited_results.push_back('{st, blk, 1'b1});
        else
            foreach (item_results[k])
                awaited_results.push_back(item_results[k]);
        if (op == OP_ALLOC)
            n_alloc++;
        else
            n_list++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    // Result checker, receiver stalls and the watchdog.
    always @(posedge aclk) begin
        chain_result_t want;
        logic          got_in;
        logic          got_out;
        got_in  = aresetn && s_axis_tvalid && s_axis_tready;
        got_out = aresetn && m_axis_tvalid && m_axis_tready;
        if (got_out) begin
            n_checked++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status=%0d block_index=%0d last=%0d",
                       m_axis_tdata[1:0], m_axis_tdata[7:2], m_axis_tlast);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[1:0] !== want.st) begin
                    $error("status: expected %0d, actual %0d", want.st, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[7:2] !== want.blk) begin
                    $error("block_index: expected %0d, actual %0d",
                           want.blk, m_axis_tdata[7:2]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        if (got_in || got_out || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic              op;
        logic [FID_W-1:0]  fid;
        logic [BIDX_W-1:0] lo;
        logic [BIDX_W-1:0] hi;
        int                pick;
        int                span;
        clear_store();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].fid, directed_rows[i].lo,
                      directed_rows[i].hi, directed_rows[i].typed, directed_rows[i].st,
                      directed_rows[i].blk);
        drain_results();

        for (int k = 0; k < N_RANDOM; k++) begin
            // Rotate through the idling patterns every 40 items.
            case ((k / 40) % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 72; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 72; end
                default: begin snd_idle_pct = 6; rcv_stall_pct = 6; end
            endcase
            if (k == 165)
                drain_results();
            pick = $urandom_range(9);
            if (pick < 7)
                fid = fid_pool[pick];
            else if (pick < 9)
                fid = 8'($urandom_range(1, 15));
            else
                fid = 8'($urandom_range(255));
            op = ($urandom_range(99) < 40) ? OP_ALLOC : OP_LIST;
            if (op == OP_ALLOC && $urandom_range(99) < 70) begin
                // Mostly short, well-formed ranges so that free blocks last a while.
                lo   = 6'($urandom_range(NBLK - 1));
                span = int'($urandom_range(3));
                hi   = 6'((int'(lo) + span > NBLK - 1) ? NBLK - 1 : int'(lo) + span);
            end else begin
                lo = 6'($urandom_range(63));
                hi = 6'($urandom_range(63));
            end
            send_item(op, fid, lo, hi, 1'b0, STAT_OK, 6'd0);
        end
        drain_results();
        repeat (300) @(posedge aclk);

        $display("Ran %0d items (%0d allocations, %0d listings) under four idling patterns;",
                 n_alloc + n_list, n_alloc, n_list);
        $display("%0d results checked, %0d mismatches.", n_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
